[rtl/core/lps_pkg.sv]
package lps_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int CFG_WIDTH       = 16;
   localparam int CSR_IDX_W       = 1;
   localparam int T_WIDTH         = 24;
   localparam int T_FRAC          = 16;

   localparam logic [CSR_IDX_W-1:0] REG_BONE_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEEL_OFF    = 1'd1;

   localparam logic [CFG_WIDTH-1:0] BONE_RESET = 16'd25600;
   localparam logic [CFG_WIDTH-1:0] EPS_RESET  = 16'd2560;

endpackage

[rtl/core/lps_mul.sv]
module lps_mul #(
   parameter int WA = 16,
   parameter int WB = 16
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WA-1:0]    a,
   input  logic [WB-1:0]    b,
   output logic [WA+WB-1:0] p
);

   localparam int LA = WA / 2;
   localparam int HA = WA - LA;
   localparam int LB = WB / 2;
   localparam int HB = WB - LB;
   localparam int WP = WA + WB;

   logic [LA+LB-1:0] ll_ff;
   logic [LA+HB-1:0] lh_ff;
   logic [HA+LB-1:0] hl_ff;
   logic [HA+HB-1:0] hh_ff;
   logic [WP-1:0]    p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= a[LA-1:0] * b[LB-1:0];
         lh_ff <= a[LA-1:0] * b[WB-1:LB];
         hl_ff <= a[WA-1:LA] * b[LB-1:0];
         hh_ff <= a[WA-1:LA] * b[WB-1:LB];
         p_ff  <= WP'(ll_ff) + (WP'(lh_ff) << LB) + (WP'(hl_ff) << LA)
                  + (WP'(hh_ff) << (LA + LB));
      end
   end

   assign p = p_ff;

endmodule

[rtl/core/lps_sqrt.sv]
module lps_sqrt #(
   parameter int SW  = 43,
   parameter int SBW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            vin,
   input  logic [SBW-1:0]  sin,
   input  logic [2*SW-1:0] n,
   output logic            vout,
   output logic [SBW-1:0]  sout,
   output logic [SW-1:0]   root
);

   localparam int RW = SW + 2;

   logic            v_ff [SW];
   logic [SBW-1:0]  s_ff [SW];
   logic [2*SW-1:0] n_ff [SW];
   logic [RW-1:0]   r_ff [SW];
   logic [SW-1:0]   q_ff [SW];

   for (genvar i = 0; i < SW; i++) begin : g_stage
      logic            vp;
      logic [SBW-1:0]  sp;
      logic [2*SW-1:0] np;
      logic [RW-1:0]   rp;
      logic [SW-1:0]   qp;
      logic [RW-1:0]   rsh;
      logic [RW-1:0]   trial;
      logic            ge;
      logic [RW-1:0]   r_in;
      logic [SW-1:0]   q_in;

      if (i == 0) begin : g_first
         assign vp = vin;
         assign sp = sin;
         assign np = n;
         assign rp = '0;
         assign qp = '0;
      end else begin : g_next
         assign vp = v_ff[i-1];
         assign sp = s_ff[i-1];
         assign np = n_ff[i-1];
         assign rp = r_ff[i-1];
         assign qp = q_ff[i-1];
      end

      assign rsh   = {rp[RW-3:0], np[2*(SW-1-i) +: 2]};
      assign trial = {qp, 2'b01};
      assign ge    = rsh >= trial;
      assign r_in  = ge ? rsh - trial : rsh;
      assign q_in  = {qp[SW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[i] <= sp;
            n_ff[i] <= np;
            r_ff[i] <= r_in;
            q_ff[i] <= q_in;
         end
      end
   end

   assign vout = v_ff[SW-1];
   assign sout = s_ff[SW-1];
   assign root = q_ff[SW-1];

endmodule

[rtl/core/lps_div.sv]
module lps_div #(
   parameter int DW  = 60,
   parameter int AW  = 50,
   parameter int SBW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           vin,
   input  logic [SBW-1:0] sin,
   input  logic [DW-1:0]  num0,
   input  logic [DW-1:0]  num1,
   input  logic [AW-1:0]  den,
   output logic           vout,
   output logic [SBW-1:0] sout,
   output logic [DW-1:0]  quo0,
   output logic [DW-1:0]  quo1
);

   logic                v_ff [DW];
   logic [SBW-1:0]      s_ff [DW];
   logic [AW-1:0]       d_ff [DW];
   logic [1:0][DW-1:0]  n_ff [DW];
   logic [1:0][DW-1:0]  q_ff [DW];
   logic [1:0][AW-1:0]  r_ff [DW];

   for (genvar i = 0; i < DW; i++) begin : g_stage
      logic               vp;
      logic [SBW-1:0]     sp;
      logic [AW-1:0]      dp;
      logic [1:0][DW-1:0] np;
      logic [1:0][DW-1:0] qp;
      logic [1:0][AW-1:0] rp;
      logic [1:0][DW-1:0] q_in;
      logic [1:0][AW-1:0] r_in;

      if (i == 0) begin : g_first
         assign vp = vin;
         assign sp = sin;
         assign dp = den;
         assign np = {num1, num0};
         assign qp = '0;
         assign rp = '0;
      end else begin : g_next
         assign vp = v_ff[i-1];
         assign sp = s_ff[i-1];
         assign dp = d_ff[i-1];
         assign np = n_ff[i-1];
         assign qp = q_ff[i-1];
         assign rp = r_ff[i-1];
      end

      for (genvar j = 0; j < 2; j++) begin : g_lane
         logic [AW:0] rsh;
         logic [AW:0] diff;
         logic        ge;

         assign rsh     = {rp[j], np[j][DW-1-i]};
         assign diff    = rsh - {1'b0, dp};
         assign ge      = rsh >= {1'b0, dp};
         assign r_in[j] = ge ? diff[AW-1:0] : rsh[AW-1:0];
         assign q_in[j] = {qp[j][DW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[i] <= sp;
            d_ff[i] <= dp;
            n_ff[i] <= np;
            q_ff[i] <= q_in;
            r_ff[i] <= r_in;
         end
      end
   end

   assign vout = v_ff[DW-1];
   assign sout = s_ff[DW-1];
   assign quo0 = q_ff[DW-1][0];
   assign quo1 = q_ff[DW-1][1];

endmodule

[rtl/core/liftoff_point_line_sphere_solver.sv]
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    tdata: cur_x cur_y cur_z nxt_x nxt_y nxt_z
// rsp      out  rsp_tvalid/tready    tdata: off_x off_y off_z t_value; tuser: valid_res
// csr      in   csr_we               csr_index, csr_wdata
//
// One word per cycle while the result is not stalled. The square root and
// divider pipelines resolve one digit per stage (SW = root bits, DW =
// quotient bits). Reset clears the stage valid bits and loads the register
// defaults. A stalled result freezes every stage; req_tready is high
// whenever the output register is empty or being taken.
module liftoff_point_line_sphere_solver #(
   parameter int COORD_WIDTH = lps_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,

   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // cur_x, cur_y, cur_z, nxt_x, nxt_y, nxt_z
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,

   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // off_x, off_y, off_z, t_value
   output logic [((3*COORD_WIDTH+lps_pkg::T_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // valid_res
   output logic [0:0]                              rsp_tuser,

   input  logic                                    csr_we,
   input  logic [lps_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [lps_pkg::CFG_WIDTH-1:0]           csr_wdata
);

   localparam int CW   = COORD_WIDTH;
   localparam int TF   = lps_pkg::T_FRAC;
   localparam int TW   = lps_pkg::T_WIDTH;
   localparam int BW   = lps_pkg::CFG_WIDTH;
   localparam int VW   = CW + 1;
   localparam int AW   = 2 * VW;
   localparam int GW   = BW + VW;
   localparam int QW   = 2 * (BW + 1);
   localparam int P1W  = 2 * GW;
   localparam int P2W  = AW + QW;
   localparam int IW   = (P1W > P2W ? P1W : P2W) + 1;
   localparam int SW   = (IW + 1) / 2;
   localparam int NW   = SW + 1;
   localparam int DW   = NW + TF;
   localparam int PW   = DW + VW;
   localparam int CAPW = (CW > BW + 1 ? CW : BW + 1) + 1;
   localparam int OUTW = ((3 * CW + TW + 7) / 8) * 8;

   localparam logic [PW-1:0]          CAP  = PW'(1) << CAPW;
   localparam logic signed [CAPW+2:0] SMAX = (CAPW+3)'((64'd1 << (CW - 1)) - 64'd1);
   localparam logic signed [CAPW+2:0] SMIN = -SMAX - (CAPW+3)'(1);
   localparam logic [DW-1:0]          TMAXP = DW'((64'd1 << (TW - 1)) - 64'd1);
   localparam logic [DW-1:0]          TMAXN = DW'(64'd1 << (TW - 1));

   typedef struct packed {
      logic [2:0]          sgn;
      logic                vzpos;
      logic [2:0][VW-1:0]  vm;
   } sb_c_type;

   typedef struct packed {
      logic                zero;
      logic                hnz;
      logic [2:0]          sgn;
      logic                vzpos;
      logic [2:0][VW-1:0]  vm;
      logic [GW-1:0]       gm;
      logic [AW-1:0]       a;
   } sb_d_type;

   typedef struct packed {
      logic                zero;
      logic                hnz;
      logic [2:0]          sgn;
      logic [2:0][VW-1:0]  vm;
      logic [1:0]          nneg;
   } sb_g_type;

   typedef struct packed {
      logic                zero;
      logic [2:0]          sgn;
      logic                tn;
      logic [DW-1:0]       tm;
   } sb_h_type;

   // pipeline advance
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // configuration
   logic [BW-1:0] bone_ff, eps_ff;
   logic [BW:0]   l_w;
   logic [QW-1:0] ll_ff, bb_ff, q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bone_ff <= lps_pkg::BONE_RESET;
         eps_ff  <= lps_pkg::EPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lps_pkg::REG_BONE_LENGTH: bone_ff <= csr_wdata;
            lps_pkg::REG_HEEL_OFF:    eps_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign l_w = {1'b0, bone_ff} + {1'b0, eps_ff};

   always_ff @(posedge clock) begin
      ll_ff <= QW'(l_w * l_w);
      bb_ff <= QW'(bone_ff * bone_ff);
      q_ff  <= ll_ff - bb_ff;
   end

   // stage A: difference
   logic                  vld_a_ff;
   logic [2:0][CW:0]      v_a_ff;
   logic [2:0][CW:0]      v_a_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         v_a_in[k] = {req_tdata[(k+3)*CW+CW-1], req_tdata[(k+3)*CW +: CW]}
                   - {req_tdata[k*CW+CW-1], req_tdata[k*CW +: CW]};
      end
   end

   // stage B: magnitudes
   logic                  vld_b_ff;
   sb_c_type              sb_b_ff, sb_b_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sb_b_in.sgn[k] = v_a_ff[k][CW];
         sb_b_in.vm[k]  = v_a_ff[k][CW] ? (~v_a_ff[k] + VW'(1)) : v_a_ff[k];
      end
      sb_b_in.vzpos = !v_a_ff[2][CW] && (v_a_ff[2] != '0);
   end

   // stage C: squares and b*|vz|
   logic [2:0][AW-1:0] sq_c;
   logic [GW-1:0]      gm_c;
   logic               vld_c1_ff, vld_c2_ff;
   sb_c_type           sb_c1_ff, sb_c2_ff;

   for (genvar k = 0; k < 3; k++) begin : g_sq
      lps_mul #(.WA(VW), .WB(VW)) u_sq (
         .clock (clock),
         .en    (adv),
         .a     (sb_b_ff.vm[k]),
         .b     (sb_b_ff.vm[k]),
         .p     (sq_c[k])
      );
   end

   lps_mul #(.WA(BW), .WB(VW)) u_gm (
      .clock (clock),
      .en    (adv),
      .a     (bone_ff),
      .b     (sb_b_ff.vm[2]),
      .p     (gm_c)
   );

   // stage D: a = v.v
   logic     vld_d_ff;
   sb_d_type sb_d_ff, sb_d_in;

   always_comb begin
      sb_d_in.a     = sq_c[0] + sq_c[1] + sq_c[2];
      sb_d_in.zero  = (sb_c2_ff.vm[0] == '0) && (sb_c2_ff.vm[1] == '0)
                      && (sb_c2_ff.vm[2] == '0);
      sb_d_in.hnz   = (sb_c2_ff.vm[0] != '0) || (sb_c2_ff.vm[1] != '0);
      sb_d_in.sgn   = sb_c2_ff.sgn;
      sb_d_in.vzpos = sb_c2_ff.vzpos;
      sb_d_in.vm    = sb_c2_ff.vm;
      sb_d_in.gm    = gm_c;
   end

   // stage E: g^2 and a*q
   logic [P1W-1:0] gg_e;
   logic [P2W-1:0] aq_e;
   logic           vld_e1_ff, vld_e2_ff;
   sb_d_type       sb_e1_ff, sb_e2_ff;

   lps_mul #(.WA(GW), .WB(GW)) u_gg (
      .clock (clock),
      .en    (adv),
      .a     (sb_d_ff.gm),
      .b     (sb_d_ff.gm),
      .p     (gg_e)
   );

   lps_mul #(.WA(AW), .WB(QW)) u_aq (
      .clock (clock),
      .en    (adv),
      .a     (sb_d_ff.a),
      .b     (q_ff),
      .p     (aq_e)
   );

   // stage F: discriminant
   logic          vld_f_ff;
   sb_d_type      sb_f_ff;
   logic [IW-1:0] inner_f_ff;

   // square root
   logic          vld_s;
   sb_d_type      sb_s;
   logic [SW-1:0] root_s;

   lps_sqrt #(.SW(SW), .SBW($bits(sb_d_type))) u_sqrt (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .vin   (vld_f_ff),
      .sin   (sb_f_ff),
      .n     ((2*SW)'(inner_f_ff)),
      .vout  (vld_s),
      .sout  (sb_s),
      .root  (root_s)
   );

   // stage G: numerators g +/- s
   logic               vld_g_ff;
   sb_g_type           sb_g_ff, sb_g_in;
   logic [AW-1:0]      a_g_ff;
   logic [1:0][DW-1:0] dvd_g_ff, dvd_g_in;
   logic signed [NW:0] g_w, s_w;
   logic [1:0][NW:0]   num_w;

   always_comb begin
      g_w = $signed({{(NW-GW+1){1'b0}}, sb_s.gm});
      if (sb_s.vzpos) begin
         g_w = -g_w;
      end
      s_w      = $signed({2'b00, root_s});
      num_w[0] = g_w + s_w;
      num_w[1] = g_w - s_w;
      for (int c = 0; c < 2; c++) begin
         sb_g_in.nneg[c] = num_w[c][NW];
         dvd_g_in[c] = {(num_w[c][NW] ? (NW'(~num_w[c]) + NW'(1)) : NW'(num_w[c])),
                        {TF{1'b0}}};
      end
      sb_g_in.zero = sb_s.zero;
      sb_g_in.hnz  = sb_s.hnz;
      sb_g_in.sgn  = sb_s.sgn;
      sb_g_in.vm   = sb_s.vm;
   end

   // divide by a
   logic          vld_q;
   sb_g_type      sb_q;
   logic [DW-1:0] quo0_q, quo1_q;

   lps_div #(.DW(DW), .AW(AW), .SBW($bits(sb_g_type))) u_div (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .vin   (vld_g_ff),
      .sin   (sb_g_ff),
      .num0  (dvd_g_ff[0]),
      .num1  (dvd_g_ff[1]),
      .den   (a_g_ff),
      .vout  (vld_q),
      .sout  (sb_q),
      .quo0  (quo0_q),
      .quo1  (quo1_q)
   );

   // stage H: root choice
   logic     vld_h_ff;
   sb_h_type sb_h_ff, sb_h_in;
   logic     tneg0_w, tneg1_w, pick0_w;

   always_comb begin
      tneg0_w = sb_q.nneg[0] && (quo0_q != '0);
      tneg1_w = sb_q.nneg[1] && (quo1_q != '0);
      pick0_w = sb_q.hnz && ((tneg0_w != tneg1_w) || (quo0_q != quo1_q));
      sb_h_in.zero = sb_q.zero;
      sb_h_in.sgn  = sb_q.sgn;
      sb_h_in.tn   = pick0_w ? tneg0_w : tneg1_w;
      sb_h_in.tm   = pick0_w ? quo0_q : quo1_q;
   end

   logic [2:0][VW-1:0] vm_h_ff;

   // stage I: t*v
   logic [2:0][PW-1:0] tv_i;
   logic               vld_i1_ff, vld_i2_ff;
   sb_h_type           sb_i1_ff, sb_i2_ff;

   for (genvar k = 0; k < 3; k++) begin : g_tv
      lps_mul #(.WA(DW), .WB(VW)) u_tv (
         .clock (clock),
         .en    (adv),
         .a     (sb_h_ff.tm),
         .b     (vm_h_ff[k]),
         .p     (tv_i[k])
      );
   end

   // stage J: offsets and saturation
   logic                vld_j_ff;
   logic [2:0][CW-1:0]  off_ff, off_in;
   logic [TW-1:0]       t_ff, t_in;
   logic                vres_ff;

   always_comb begin
      logic [PW-1:0]        pm;
      logic signed [CAPW+2:0] tv, hk, diff;
      for (int k = 0; k < 3; k++) begin
         pm = tv_i[k] >> TF;
         if (pm > CAP) begin
            pm = CAP;
         end
         tv = $signed({2'b00, pm[CAPW:0]});
         if (sb_i2_ff.tn != sb_i2_ff.sgn[k]) begin
            tv = -tv;
         end
         hk = '0;
         if (k == 2) begin
            hk = -$signed({{(CAPW+3-BW){1'b0}}, bone_ff});
         end
         diff = hk - tv;
         if (diff > SMAX) begin
            off_in[k] = SMAX[CW-1:0];
         end else if (diff < SMIN) begin
            off_in[k] = SMIN[CW-1:0];
         end else begin
            off_in[k] = diff[CW-1:0];
         end
         if (sb_i2_ff.zero) begin
            off_in[k] = '0;
         end
      end
      if (!sb_i2_ff.tn) begin
         t_in = (sb_i2_ff.tm > TMAXP) ? TMAXP[TW-1:0] : sb_i2_ff.tm[TW-1:0];
      end else begin
         t_in = (sb_i2_ff.tm > TMAXN) ? TMAXN[TW-1:0]
              : (~sb_i2_ff.tm[TW-1:0] + TW'(1));
      end
      if (sb_i2_ff.zero) begin
         t_in = '0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff  <= 1'b0;
         vld_b_ff  <= 1'b0;
         vld_c1_ff <= 1'b0;
         vld_c2_ff <= 1'b0;
         vld_d_ff  <= 1'b0;
         vld_e1_ff <= 1'b0;
         vld_e2_ff <= 1'b0;
         vld_f_ff  <= 1'b0;
         vld_g_ff  <= 1'b0;
         vld_h_ff  <= 1'b0;
         vld_i1_ff <= 1'b0;
         vld_i2_ff <= 1'b0;
         vld_j_ff  <= 1'b0;
      end else if (adv) begin
         vld_a_ff  <= req_tvalid;
         vld_b_ff  <= vld_a_ff;
         vld_c1_ff <= vld_b_ff;
         vld_c2_ff <= vld_c1_ff;
         vld_d_ff  <= vld_c2_ff;
         vld_e1_ff <= vld_d_ff;
         vld_e2_ff <= vld_e1_ff;
         vld_f_ff  <= vld_e2_ff;
         vld_g_ff  <= vld_s;
         vld_h_ff  <= vld_q;
         vld_i1_ff <= vld_h_ff;
         vld_i2_ff <= vld_i1_ff;
         vld_j_ff  <= vld_i2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         v_a_ff     <= v_a_in;
         sb_b_ff    <= sb_b_in;
         sb_c1_ff   <= sb_b_ff;
         sb_c2_ff   <= sb_c1_ff;
         sb_d_ff    <= sb_d_in;
         sb_e1_ff   <= sb_d_ff;
         sb_e2_ff   <= sb_e1_ff;
         sb_f_ff    <= sb_e2_ff;
         inner_f_ff <= IW'(gg_e) + IW'(aq_e);
         sb_g_ff    <= sb_g_in;
         a_g_ff     <= sb_s.a;
         dvd_g_ff   <= dvd_g_in;
         sb_h_ff    <= sb_h_in;
         vm_h_ff    <= sb_q.vm;
         sb_i1_ff   <= sb_h_ff;
         sb_i2_ff   <= sb_i1_ff;
         off_ff     <= off_in;
         t_ff       <= t_in;
         vres_ff    <= !sb_i2_ff.zero;
      end
   end

   assign rsp_tvalid = vld_j_ff;
   assign rsp_tdata  = OUTW'({t_ff, off_ff[2], off_ff[1], off_ff[0]});
   assign rsp_tuser  = vres_ff;

endmodule
